// ----- rtl/fcft_pkg.sv -----
`default_nettype none

package fcft_pkg;

   // accumulator, result and reciprocal widths shared with the scaler
   localparam int ACC_W       = 64;
   localparam int OUT_W       = 48;
   localparam int RECIP_EXT_W = 25;

   // request into the scaling pipeline
   typedef struct packed {
      logic                   start;
      logic [ACC_W-1:0]       acc;
      logic [RECIP_EXT_W-1:0] recip;
   } scale_req_type;

   // scaled and saturated result back to the top level
   typedef struct packed {
      logic                    done;
      logic signed [OUT_W-1:0] value;
   } scale_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/fcft_scale.sv -----
`default_nettype none

// floor(acc*recip/2^32) via the magnitude, then 48-bit saturation and sign restore
module fcft_scale (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire fcft_pkg::scale_req_type req,
   output fcft_pkg::scale_rsp_type      rsp
);

   localparam int ACC_W   = fcft_pkg::ACC_W;
   localparam int OUT_W   = fcft_pkg::OUT_W;
   localparam int R_W     = fcft_pkg::RECIP_EXT_W;
   localparam int HALF_W  = ACC_W / 2;
   localparam int PP_W    = HALF_W + R_W;
   localparam int Q_W     = PP_W + 1;
   localparam int STAGES  = 5;
   localparam logic [Q_W-1:0] POS_LIMIT = Q_W'((64'd1 << (OUT_W - 1)) - 64'd1);
   localparam logic [Q_W-1:0] NEG_LIMIT = Q_W'(64'd1 << (OUT_W - 1));

   logic [STAGES-1:0] vld_ff;
   logic              neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [ACC_W-1:0]  m1_ff, m1_in;
   logic [R_W-1:0]    r1_ff, r2_ff;
   logic [HALF_W-1:0] mh2_ff;
   logic [PP_W-1:0]   lo2_ff, lo3_ff, hi3_ff;
   logic [Q_W-1:0]    q4_ff, q4_in, qs;
   logic [OUT_W-1:0]  res_ff, res_in;

   // magnitude of the accumulator
   assign m1_in = req.acc[ACC_W-1] ? (ACC_W'(0) - req.acc) : req.acc;

   // high partial product plus carried low part, round toward minus infinity
   assign q4_in = Q_W'(hi3_ff) + Q_W'(lo3_ff[PP_W-1:HALF_W])
                + Q_W'(neg3_ff && (lo3_ff[HALF_W-1:0] != '0));

   // saturate magnitude, then restore sign
   always_comb begin
      if (neg4_ff) begin
         qs     = (q4_ff > NEG_LIMIT) ? NEG_LIMIT : q4_ff;
         res_in = OUT_W'(Q_W'(0) - qs);
      end else begin
         qs     = (q4_ff > POS_LIMIT) ? POS_LIMIT : q4_ff;
         res_in = OUT_W'(qs);
      end
   end

   // stage valid shift
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[STAGES-2:0], req.start};
      end
   end

   // datapath stages
   always_ff @(posedge clock) begin
      neg1_ff <= req.acc[ACC_W-1];
      m1_ff   <= m1_in;
      r1_ff   <= req.recip;
      neg2_ff <= neg1_ff;
      mh2_ff  <= m1_ff[ACC_W-1:HALF_W];
      r2_ff   <= r1_ff;
      lo2_ff  <= PP_W'(m1_ff[HALF_W-1:0]) * PP_W'(r1_ff);
      neg3_ff <= neg2_ff;
      lo3_ff  <= lo2_ff;
      hi3_ff  <= PP_W'(mh2_ff) * PP_W'(r2_ff);
      neg4_ff <= neg3_ff;
      q4_ff   <= q4_in;
      res_ff  <= res_in;
   end

   assign rsp.done  = vld_ff[STAGES-1];
   assign rsp.value = res_ff;

endmodule

`default_nettype wire

// ----- rtl/finite_cusp_flat_top_filter_top.sv -----
`default_nettype none

// channel   direction  ports                           contents
// req       in         req_tvalid/tready/tdata/tuser   sample in, first-of-waveform flag
// rsp       out        rsp_tvalid/tready/tdata         shaped sample
// csr       in         csr_wr_en/csr_index/csr_wdata   five shaping registers
//
// one sample at a time: a sample is taken only once the last one's result has
// moved to the output register; the pace is set by three tap reads through the
// single read port of the history memory, the shared multiplier and the 5-stage scaler.
// a finished result sits in the output register; the next sample is taken
// while it waits. reset is synchronous and clears all filter state.
module finite_cusp_flat_top_filter_top #(
   parameter int MAX_DELAY   = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // tdata: sample [SAMPLE_BITS-1:0], zero fill above
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,
   // tuser: first
   input  wire logic                                 req_tuser,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // tdata: shaped [47:0]
   output logic [fcft_pkg::OUT_W-1:0]                rsp_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic                                 csr_wr_en,
   input  wire logic [2:0]                           csr_index,
   input  wire logic [23:0]                          csr_wdata
);

   localparam int SB      = SAMPLE_BITS;
   localparam int AW      = $clog2(MAX_DELAY);
   localparam int CW      = $clog2(MAX_DELAY + 1);
   localparam int DLY_W   = 14;
   localparam int AXW     = ((AW > DLY_W) ? AW : DLY_W) + 1;
   localparam int ACC_W   = fcft_pkg::ACC_W;
   localparam int R_W     = fcft_pkg::RECIP_EXT_W;
   localparam int SUM_W   = 48;
   localparam int S_W     = 49;
   localparam int S_LO_W  = 25;
   localparam int TW      = SB + 2;
   localparam int ABW     = SB + 13;
   localparam int WW      = SB + 14;
   localparam int MUL_A_W = 22;
   localparam int MUL_B_W = 26;
   localparam int MUL_P_W = 48;
   localparam int FRAC_SH = 8;
   localparam logic [MUL_A_W-1:0] ONE_Q8      = MUL_A_W'(256);
   localparam logic [R_W-1:0]     UNITY_RECIP = R_W'(1) << 24;

   localparam logic [2:0] CSR_RAMP_LEN   = 3'd0;
   localparam logic [2:0] CSR_FLAT_LEN   = 3'd1;
   localparam logic [2:0] CSR_DECAY      = 3'd2;
   localparam logic [2:0] CSR_NORM_ON    = 3'd3;
   localparam logic [2:0] CSR_NORM_RECIP = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD_A, ST_RD_B, ST_RD_C, ST_SUM, ST_P, ST_S,
      ST_MUL_LO, ST_MUL_HI, ST_ACC, ST_SCALE, ST_WAIT, ST_OUT
   } state_type;

   state_type state_ff, state_in;

   // shaping registers
   logic [10:0] ramp_ff;
   logic [11:0] flat_ff;
   logic [19:0] decay_ff;
   logic        norm_on_ff;
   logic [23:0] recip_ff;

   // filter state
   logic [AW-1:0]           wp_ff, wp_in;
   logic [CW-1:0]           count_ff, count_in;
   logic signed [SUM_W-1:0] cusp_ff, cusp_in;
   logic [ACC_W-1:0]        pz_ff, pz_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;

   // per-sample working registers
   logic signed [SB-1:0]      x_ff;
   logic                      first_ff;
   logic                      tap_zero_ff, tap_ok_ff;
   logic signed [SB-1:0]      a_ff, b_ff, rdata_ff;
   logic signed [TW-1:0]      t_ff, t_in;
   logic signed [ABW-1:0]     abr_ff, abr_in;
   logic signed [SB:0]        cb_ff, cb_in;
   logic signed [SUM_W-1:0]   p_ff, p_in;
   logic signed [WW-1:0]      w_ff, w_in;
   logic signed [S_W-1:0]     s_ff, s_in;
   logic signed [MUL_P_W-1:0] mul_ff, mul_in, mul_lo_ff;

   // output register
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [fcft_pkg::OUT_W-1:0] rsp_tdata_ff;

   // history memory
   logic [SB-1:0] hist_mem [MAX_DELAY];
   logic [AW-1:0] rd_addr;
   logic          mem_we;

   logic [DLY_W-1:0]  d1, d2, d3, tap_d;
   logic [AXW-1:0]    diff, diff_fix;
   logic              tap_zero, tap_ok;
   logic signed [SB-1:0] tap_val;
   logic signed [SB:0]   ab_sum;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic              decay_on, req_xfer, rsp_load;

   fcft_pkg::scale_req_type sc_req;
   fcft_pkg::scale_rsp_type sc_rsp;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign decay_on   = (decay_ff != '0);
   assign rsp_load   = (state_ff == ST_OUT) && (!rsp_tvalid_ff || rsp_tready);

   // tap delays
   assign d1 = DLY_W'(ramp_ff);
   assign d2 = DLY_W'(flat_ff) + DLY_W'(ramp_ff);
   assign d3 = d2 + DLY_W'(ramp_ff);

   // tap address and validity for the read issued this cycle
   always_comb begin
      unique case (state_ff)
         ST_RD_A: tap_d = d1;
         ST_RD_B: tap_d = d2;
         default: tap_d = d3;
      endcase
      tap_zero = (tap_d == '0);
      tap_ok   = !tap_zero && (32'(tap_d) < 32'(MAX_DELAY))
                 && (32'(tap_d) <= 32'(count_ff));
      diff     = AXW'(wp_ff) - AXW'(tap_d);
      diff_fix = diff[AXW-1] ? (diff + AXW'(MAX_DELAY)) : diff;
      rd_addr  = tap_ok ? AW'(diff_fix) : '0;
   end

   // tap value, seen in the cycle after its read
   assign tap_val = tap_zero_ff ? x_ff : (tap_ok_ff ? rdata_ff : '0);

   // memory port
   assign mem_we = (state_ff == ST_SUM);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[wp_ff] <= x_ff;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= hist_mem[rd_addr];
   end

   // cusp terms
   assign ab_sum = (SB+1)'(a_ff) + (SB+1)'(b_ff);
   assign t_in   = TW'(x_ff) - TW'(a_ff) + TW'(b_ff) - TW'(tap_val);
   assign abr_in = ABW'(ab_sum) * ABW'(signed'({1'b0, ramp_ff}));
   assign cb_in  = (SB+1)'(tap_val) - (SB+1)'(b_ff);
   assign p_in   = cusp_ff + SUM_W'(t_ff);
   assign w_in   = WW'(abr_ff) - WW'(cb_ff);
   assign s_in   = S_W'(p_ff) - S_W'(w_ff);

   // shared multiplier: restart gain, then low and high halves of decay * s
   always_comb begin
      if (state_ff == ST_MUL_LO) begin
         if (first_ff) begin
            mul_a = signed'(MUL_A_W'(decay_ff) + ONE_Q8);
            mul_b = MUL_B_W'(x_ff);
         end else begin
            mul_a = signed'(MUL_A_W'(decay_ff));
            mul_b = signed'({1'b0, s_ff[S_LO_W-1:0]});
         end
      end else begin
         mul_a = signed'(MUL_A_W'(decay_ff));
         mul_b = MUL_B_W'(signed'(s_ff[S_W-1:S_LO_W]));
      end
      mul_in = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
   end

   // next state and filter state updates
   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      count_in      = count_ff;
      cusp_in       = cusp_ff;
      pz_in         = pz_ff;
      acc_in        = acc_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_RD_A;
            end
         end
         ST_RD_A: state_in = ST_RD_B;
         ST_RD_B: state_in = ST_RD_C;
         ST_RD_C: state_in = ST_SUM;
         ST_SUM: begin
            state_in = ST_P;
            wp_in    = (wp_ff == AW'(MAX_DELAY - 1)) ? '0 : (wp_ff + AW'(1));
            if (first_ff) begin
               count_in = CW'(1);
            end else if (32'(count_ff) < 32'(MAX_DELAY)) begin
               count_in = count_ff + CW'(1);
            end
         end
         ST_P: begin
            state_in = ST_S;
            cusp_in  = first_ff ? '0 : p_in;
         end
         ST_S: state_in = ST_MUL_LO;
         ST_MUL_LO: begin
            state_in = ST_MUL_HI;
            if (first_ff) begin
               pz_in = ACC_W'(x_ff);
            end else if (decay_on) begin
               pz_in = pz_ff + ACC_W'(s_ff);
            end
         end
         ST_MUL_HI: begin
            state_in = ST_ACC;
            if (!first_ff && decay_on) begin
               acc_in = acc_ff + (pz_ff << FRAC_SH);
            end
         end
         ST_ACC: begin
            state_in = ST_SCALE;
            if (first_ff) begin
               acc_in = ACC_W'(mul_lo_ff);
            end else if (decay_on) begin
               acc_in = acc_ff + ACC_W'(mul_lo_ff) + (ACC_W'(mul_ff) << S_LO_W);
            end else begin
               acc_in = acc_ff + (ACC_W'(s_ff) << FRAC_SH);
            end
         end
         ST_SCALE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (sc_rsp.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in      = ST_IDLE;
               rsp_tvalid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state, filter state and shaping registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wp_ff         <= '0;
         count_ff      <= '0;
         cusp_ff       <= '0;
         pz_ff         <= '0;
         acc_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
         ramp_ff       <= 11'd1;
         flat_ff       <= '0;
         decay_ff      <= '0;
         norm_on_ff    <= 1'b1;
         recip_ff      <= '1;
      end else begin
         state_ff      <= state_in;
         wp_ff         <= wp_in;
         count_ff      <= count_in;
         cusp_ff       <= cusp_in;
         pz_ff         <= pz_in;
         acc_ff        <= acc_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_RAMP_LEN:   ramp_ff    <= csr_wdata[10:0];
               CSR_FLAT_LEN:   flat_ff    <= csr_wdata[11:0];
               CSR_DECAY:      decay_ff   <= csr_wdata[19:0];
               CSR_NORM_ON:    norm_on_ff <= csr_wdata[0];
               CSR_NORM_RECIP: recip_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         x_ff     <= req_tdata[SB-1:0];
         first_ff <= req_tuser;
      end
      tap_zero_ff <= tap_zero;
      tap_ok_ff   <= tap_ok;
      if (state_ff == ST_RD_B) begin
         a_ff <= tap_val;
      end
      if (state_ff == ST_RD_C) begin
         b_ff <= tap_val;
      end
      if (state_ff == ST_SUM) begin
         t_ff   <= t_in;
         abr_ff <= abr_in;
         cb_ff  <= cb_in;
      end
      if (state_ff == ST_P) begin
         p_ff <= p_in;
         w_ff <= w_in;
      end
      if (state_ff == ST_S) begin
         s_ff <= s_in;
      end
      if (state_ff == ST_MUL_LO || state_ff == ST_MUL_HI) begin
         mul_ff <= mul_in;
      end
      if (state_ff == ST_MUL_HI) begin
         mul_lo_ff <= mul_ff;
      end
      if (rsp_load) begin
         rsp_tdata_ff <= sc_rsp.value;
      end
   end

   // scaling and saturation
   assign sc_req.start = (state_ff == ST_SCALE);
   assign sc_req.acc   = acc_ff;
   assign sc_req.recip = norm_on_ff ? R_W'(recip_ff) : UNITY_RECIP;

   fcft_scale u_scale (
      .clock (clock),
      .reset (reset),
      .req   (sc_req),
      .rsp   (sc_rsp)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire

// ----- rtl/fcft_checker.sv -----
`default_nettype none

module fcft_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata
);

   // a stalled result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one sample in flight: no transfer right after a transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after a transfer");

   // a new result appears as the block returns to taking samples
   a_result_frees_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("new result without input ready");

   // reset leaves no result pending and input ready
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

endmodule

bind finite_cusp_flat_top_filter_top fcft_checker u_fcft_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ----- tb/fcft_tb_pkg.sv -----
package fcft_tb_pkg;

   // shaping register indexes on the csr port
   typedef enum logic [2:0] {
      REG_RAMP_LEN,
      REG_FLAT_LEN,
      REG_DECAY,
      REG_NORM_ON,
      REG_NORM_RECIP
   } csr_reg_type;

   // indexes from here up are not decoded
   localparam int NUM_REGS = 5;

endpackage

// ----- tb/fcft_shape_checker.sv -----
module fcft_shape_checker #(
   parameter int MAX_DELAY   = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,
   input  wire logic                                 req_tuser,
   input  wire logic                                 req_tvalid,
   input  wire logic                                 req_tready,
   input  wire logic [fcft_pkg::OUT_W-1:0]           rsp_tdata,
   input  wire logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic                                 csr_wr_en,
   input  wire logic [2:0]                           csr_index,
   input  wire logic [23:0]                          csr_wdata,
   output int                                        mismatch_count,
   output int                                        pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // saturation bounds of the shaped output
   localparam logic signed [127:0] SHAPED_MAX =
      (128'sd1 <<< (fcft_pkg::OUT_W-1)) - 128'sd1;
   localparam logic signed [127:0] SHAPED_MIN = -(128'sd1 <<< (fcft_pkg::OUT_W-1));

   // shadow of the shaping registers
   logic [10:0] ramp_len;
   logic [11:0] flat_len;
   logic [19:0] decay;
   logic        norm_on;
   logic [23:0] recip;

   // shadow filter state
   logic signed [SAMPLE_BITS-1:0] history [MAX_DELAY];
   int unsigned                   wr_ptr;
   int unsigned                   seen;
   logic [47:0]                   cusp;
   logic [63:0]                   pz_acc;
   logic [63:0]                   out_acc;

   logic [fcft_pkg::OUT_W-1:0] shaped_q [$];
   int               err_total = 0;
   int               in_flight = 0;

   assign mismatch_count = err_total;
   assign pending_count  = in_flight;

   // delayed sample, zero when it reaches before the waveform start or past the store
   function automatic logic [63:0] tap_at(input int unsigned delay, input logic [63:0] x);
      logic signed [63:0] t;
      if (delay == 0)
         return x;
      if (delay >= MAX_DELAY || delay > seen)
         return '0;
      t = history[(wr_ptr + MAX_DELAY - delay) % MAX_DELAY];
      return t;
   endfunction

   // advance the filter by one sample and return the shaped value
   function automatic logic [fcft_pkg::OUT_W-1:0] shape_next(
      input logic signed [SAMPLE_BITS-1:0] smp,
      input logic first);
      logic signed [63:0]  x;
      logic signed [63:0]  p;
      logic signed [47:0]  p48;
      logic [63:0]         a, b, c, s;
      logic [24:0]         factor;
      logic signed [127:0] prod;
      int unsigned         d1, d2, d3;
      x = smp;
      if (first) begin
         seen    = 0;
         cusp    = '0;
         pz_acc  = x;
         out_acc = (64'(decay) + 64'd256) * x;
      end else begin
         d1 = ramp_len;
         d2 = flat_len + ramp_len;
         d3 = flat_len + 2 * ramp_len;
         a = tap_at(d1, x);
         b = tap_at(d2, x);
         c = tap_at(d3, x);
         // running cusp sum wraps at 48 bits
         cusp = 48'(cusp + x - a + b - c);
         p48  = cusp;
         p    = p48;
         s    = p - (a + b) * 64'(ramp_len) - b + c;
         if (decay != 0) begin
            pz_acc  = pz_acc + s;
            out_acc = out_acc + 64'd256 * pz_acc + 64'(decay) * s;
         end else begin
            out_acc = out_acc + 64'd256 * s;
         end
      end
      history[wr_ptr] = smp;
      wr_ptr = (wr_ptr + 1) % MAX_DELAY;
      if (seen < MAX_DELAY)
         seen++;
      // scale with floor, then clamp to 48 bits
      factor = norm_on ? {1'b0, recip} : 25'(1 << 24);
      prod   = $signed(out_acc);
      prod   = (prod * $signed({103'd0, factor})) >>> 32;
      if (prod > SHAPED_MAX)
         prod = SHAPED_MAX;
      else if (prod < SHAPED_MIN)
         prod = SHAPED_MIN;
      return prod[fcft_pkg::OUT_W-1:0];
   endfunction

   // watch all three ports, predict on each input transfer, compare on each result transfer
   always @(posedge clock) begin
      logic [fcft_pkg::OUT_W-1:0] want;
      if (reset) begin
         ramp_len = 11'd1;
         flat_len = '0;
         decay    = '0;
         norm_on  = 1'b1;
         recip    = 24'hFFFFFF;
         wr_ptr   = 0;
         seen     = 0;
         cusp     = '0;
         pz_acc   = '0;
         out_acc  = '0;
         shaped_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (shaped_q.size() == 0) begin
               $error("shaped: no sample pending, actual %0d", $signed(rsp_tdata));
               err_total++;
            end else begin
               want = shaped_q.pop_front();
               if (rsp_tdata !== want) begin
                  $error("shaped: expected %0d, actual %0d", $signed(want), $signed(rsp_tdata));
                  err_total++;
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               fcft_tb_pkg::REG_RAMP_LEN:   ramp_len = csr_wdata[10:0];
               fcft_tb_pkg::REG_FLAT_LEN:   flat_len = csr_wdata[11:0];
               fcft_tb_pkg::REG_DECAY:      decay    = csr_wdata[19:0];
               fcft_tb_pkg::REG_NORM_ON:    norm_on  = csr_wdata[0];
               fcft_tb_pkg::REG_NORM_RECIP: recip    = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            shaped_q.push_back(shape_next(req_tdata[SAMPLE_BITS-1:0], req_tuser));
      end
      in_flight <= shaped_q.size();
   end

endmodule

// ----- tb/finite_cusp_flat_top_filter_top_tb.sv -----
module finite_cusp_flat_top_filter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DELAY   = 4096;
   localparam int SAMPLE_BITS = 16;
   localparam int LONG_RUN    = 60;
   localparam int SWING_AT    = 30;
   localparam int NUM_PHASES  = 8;
   localparam int PHASE_ITEMS = 45;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic [15:0]          req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [fcft_pkg::OUT_W-1:0] rsp_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b1;
   logic                 csr_wr_en  = 1'b0;
   logic [2:0]           csr_index  = '0;
   logic [23:0]          csr_wdata  = '0;
   int                   mismatch_count;
   int                   pending_count;

   int req_calm  = 0;
   int rsp_calm  = 0;
   int rsp_stall = 0;

   finite_cusp_flat_top_filter_top #(
      .MAX_DELAY   (MAX_DELAY),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   fcft_shape_checker #(
      .MAX_DELAY   (MAX_DELAY),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // 100 MHz clock
   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #40ms;
      $display("finite_cusp_flat_top_filter_top_tb failed");
      $finish;
   end

   // result side backpressure: short and long stalls, calm stretches
   always @(negedge clock) begin
      int r;
      if (rsp_calm > 0) begin
         rsp_calm--;
         rsp_tready = 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready = 1'b0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            rsp_calm   = $urandom_range(30, 150);
            rsp_tready = 1'b1;
         end else if (r < 22) begin
            rsp_stall  = $urandom_range(0, 3);
            rsp_tready = 1'b0;
         end else if (r < 26) begin
            rsp_stall  = $urandom_range(10, 45);
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // idle cycles ahead of the next sample
   function automatic int pick_gap();
      int r;
      if (req_calm > 0) begin
         req_calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         req_calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 45);
   endfunction

   // sample mix: full range, extremes, small values around zero
   function automatic logic [15:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 16'($urandom);
      if (r < 60) begin
         case ($urandom_range(0, 3))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'hFFFF;
         endcase
      end
      return 16'(int'($urandom_range(0, 600)) - 300);
   endfunction

   // one sample transfer; valid stays up until the next falling edge
   task automatic push_sample(input logic [15:0] smp, input logic first);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = smp;
      req_tuser  = first;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending and wait for every outstanding result
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [23:0] val);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic apply_settings(input logic [10:0] ramp, input logic [11:0] flat,
                                 input logic [19:0] decay, input logic norm,
                                 input logic [23:0] recip);
      wait_drained();
      csr_write(fcft_tb_pkg::REG_RAMP_LEN, 24'(ramp));
      csr_write(fcft_tb_pkg::REG_FLAT_LEN, 24'(flat));
      csr_write(fcft_tb_pkg::REG_DECAY, 24'(decay));
      csr_write(fcft_tb_pkg::REG_NORM_ON, 24'(norm));
      csr_write(fcft_tb_pkg::REG_NORM_RECIP, recip);
   endtask

   initial begin
      int          r, sent, len;
      logic        restart;
      logic [10:0] ramp;
      logic [11:0] flat;
      logic [19:0] decay;
      logic        norm;
      logic [23:0] recip;
      logic [15:0] smp;

      repeat (11) @(negedge clock);
      reset = 1'b0;

      // reset settings, samples ahead of any waveform start
      push_sample(16'h7FFF, 1'b0);
      push_sample(16'h8000, 1'b0);
      push_sample(16'hFFFF, 1'b0);
      push_sample(16'h0001, 1'b0);
      // restarts at both extremes, then continuation
      push_sample(16'h8000, 1'b1);
      push_sample(16'h7FFF, 1'b0);
      push_sample(16'h8000, 1'b0);
      push_sample(16'h0000, 1'b0);
      push_sample(16'h7FFF, 1'b1);
      push_sample(16'h7FFF, 1'b0);
      push_sample(16'h5555, 1'b0);
      push_sample(16'hAAAA, 1'b0);

      // zero ramp: every tap but the flat ones is the current sample
      wait_drained();
      csr_write(fcft_tb_pkg::REG_RAMP_LEN, 24'd0);
      csr_write(fcft_tb_pkg::REG_FLAT_LEN, 24'd3);
      csr_write(fcft_tb_pkg::REG_NORM_ON, 24'd0);
      push_sample(16'h1234, 1'b1);
      push_sample(16'h8000, 1'b0);
      push_sample(16'h7FFF, 1'b0);
      push_sample(16'h0F0F, 1'b0);

      // widest ramp and flat top: outer taps fall past the store
      apply_settings(11'd2047, 12'd4095, 20'hFFFFF, 1'b1, 24'hFFFFFF);
      push_sample(16'h7FFF, 1'b1);
      push_sample(16'h7FFF, 1'b0);
      push_sample(16'h8000, 1'b0);

      // zero reciprocal
      wait_drained();
      csr_write(fcft_tb_pkg::REG_NORM_RECIP, 24'd0);
      push_sample(16'h7FFF, 1'b0);
      push_sample(16'h8000, 1'b0);

      // undecoded indexes must leave the settings alone
      wait_drained();
      csr_write(fcft_tb_pkg::REG_DECAY, 24'd0);
      csr_write(fcft_tb_pkg::REG_NORM_RECIP, 24'hABCDEF);
      for (int i = fcft_tb_pkg::NUM_REGS; i < (1 << $bits(csr_index)); i++)
         csr_write(3'(i), 24'hFFFFFF);
      push_sample(16'h4000, 1'b1);
      push_sample(16'hC000, 1'b0);
      push_sample(16'h7FFF, 1'b0);

      // random settings, mostly short taps, waveforms of random length
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         r = $urandom_range(0, 99);
         ramp = (r < 5) ? 11'd0 : (r < 12) ? 11'd2047 : 11'($urandom_range(1, 8));
         r = $urandom_range(0, 99);
         flat = (r < 10) ? 12'd4095 : 12'($urandom_range(0, 16));
         r = $urandom_range(0, 99);
         if (r < 30)
            decay = '0;
         else if (r < 45)
            decay = 20'hFFFFF;
         else if (r < 65)
            decay = 20'($urandom_range(256, 4096));
         else
            decay = 20'($urandom);
         norm = 1'($urandom_range(0, 1));
         r = $urandom_range(0, 99);
         recip = (r < 15) ? 24'd0 : (r < 30) ? 24'hFFFFFF : 24'($urandom);
         apply_settings(ramp, flat, decay, norm, recip);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            len     = $urandom_range(1, 40);
            restart = ($urandom_range(0, 9) != 0);
            for (int k = 0; k < len; k++) begin
               push_sample(pick_sample(), restart && (k == 0));
               sent++;
            end
            if ($urandom_range(0, 7) == 0)
               wait_drained();
         end
      end

      // one longer waveform with every tap in reach, swinging from the top rail to the bottom
      apply_settings(11'd12, 12'd20, 20'hFFFFF, 1'b0, 24'($urandom));
      for (int k = 0; k < LONG_RUN; k++) begin
         if (k < SWING_AT)
            smp = 16'h7FFF - 16'($urandom_range(0, 255));
         else
            smp = 16'h8000 + 16'($urandom_range(0, 255));
         push_sample(smp, k == 0);
      end

      wait_drained();
      repeat (40) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("finite_cusp_flat_top_filter_top_tb passed");
      else
         $display("finite_cusp_flat_top_filter_top_tb failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/fcft_pkg.sv
rtl/fcft_scale.sv
rtl/finite_cusp_flat_top_filter_top.sv
rtl/fcft_checker.sv
tb/fcft_tb_pkg.sv
tb/fcft_shape_checker.sv
tb/finite_cusp_flat_top_filter_top_tb.sv
